// ----- design/stl_pkg.sv -----
package stl_pkg;

	// Token kinds as they appear on the output.
	localparam logic [2:0] KIND_SYM   = 3'd0;
	localparam logic [2:0] KIND_TILDE = 3'd1;
	localparam logic [2:0] KIND_OPEN  = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_QUOTE = 3'd4;
	localparam logic [2:0] KIND_STR   = 3'd5;
	localparam logic [2:0] KIND_OTHER = 3'd6;
	localparam logic [2:0] KIND_NONE  = 3'd7;

	// Error codes.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNMATCHED = 2'd1;
	localparam logic [1:0] ERR_ORPHAN    = 2'd2;
	localparam logic [1:0] ERR_DEEP      = 2'd3;

	// Characters with a meaning to the lexer.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} src_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [2:0]  token_kind;
		logic        token_start;
		logic        stream_end;
		logic [1:0]  error_code;
		logic [7:0]  error_glyph;
		logic [15:0] error_line;
		logic [15:0] error_col;
	} tok_item_t;

	// One entry of the open-bracket stack.
	typedef struct packed {
		logic [7:0]  glyph;
		logic [15:0] line;
		logic [15:0] col;
	} stack_entry_t;

	function automatic logic is_word_char(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39) || b == CH_USCORE || b == CH_DASH;
	endfunction

endpackage

// ----- design/stl_chan_if.sv -----
interface stl_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/stl_ram.sv -----
module stl_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/sexpr_token_lexer_core.sv -----
// Streaming lexer for Lisp source text. It takes one source byte per clock
// cycle when the output is not stalled and emits one transaction per token
// byte, with its kind and a token-start mark; whitespace, commas and ;-comments
// give nothing. A zero byte outside a string or comment, or a byte marked last,
// ends the stream with one end-marker transaction that reports the innermost
// bracket still open, after which all state returns to its reset values.
// Results leave the output register in the cycle after their byte is taken.
// A byte that yields both a token and the end marker stalls the input, so the
// sustained input rate is one byte per cycle except for those bytes. Open
// brackets with their line and column live in a STACK_DEPTH-entry RAM with
// registered read; the top entry is read in the cycle the byte is taken, and
// a push to the same entry is forwarded. The RAM needs no clearing after reset.
module sexpr_token_lexer_core
	import stl_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	stl_chan_if.sink   source_text,
	stl_chan_if.source tokens
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_SYM,
		MODE_TILDE,
		MODE_STR,
		MODE_STR_ESC,
		MODE_COMMENT
	} mode_t;

	mode_t          mode_q;
	logic [15:0]    line_q;
	logic [15:0]    col_q;
	logic [CW-1:0]  open_cnt_q;

	// Lexing of the incoming byte.
	logic [7:0]     b;
	logic           last;
	logic           word;
	logic           stop0;
	logic           nl;
	logic [15:0]    line_adv;
	logic [15:0]    col_adv;
	mode_t          mode_n;
	logic           tok_v;
	logic [2:0]     kind;
	logic           start;
	logic [1:0]     err;
	logic [CW-1:0]  cnt_n;
	logic [CW-1:0]  rd_cnt;
	logic           push;
	logic           do_idle;
	logic           end_v;
	logic           in_fire;
	logic           out_fire;

	// RAM access.
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [AW-1:0]  mem_raddr;
	stack_entry_t   mem_wdata;
	stack_entry_t   mem_rdata;

	// Output stage.
	logic           tok_v_s1;
	logic           end_v_s1;
	logic [7:0]     byte_s1;
	logic [2:0]     kind_s1;
	logic           start_s1;
	logic [1:0]     err_s1;
	logic [15:0]    line_s1;
	logic [15:0]    col_s1;
	logic           has_open_s1;
	logic           fwd_s1;
	stack_entry_t   fwd_data_s1;
	logic           cap_q;
	stack_entry_t   top_q;
	stack_entry_t   top_live;
	stack_entry_t   top;
	logic           busy;
	logic           last_res;

	always_comb begin
		b = source_text.payload.in_byte;
		last = source_text.payload.in_last;
		word = is_word_char(b);
		stop0 = (b == CH_NUL) &&
			(mode_q == MODE_IDLE || mode_q == MODE_SYM || mode_q == MODE_TILDE);
		nl = (b == CH_NL);
		line_adv = (nl && line_q != POS_MAX) ? line_q + 16'd1 : line_q;
		col_adv = nl ? 16'd1 : ((col_q != POS_MAX) ? col_q + 16'd1 : col_q);

		mode_n = mode_q;
		tok_v = 1'b0;
		kind = KIND_OTHER;
		start = 1'b0;
		err = ERR_NONE;
		cnt_n = open_cnt_q;
		push = 1'b0;
		do_idle = 1'b0;

		if (!stop0) begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (nl) begin
						mode_n = MODE_IDLE;
					end
				end
				MODE_STR_ESC: begin
					tok_v = 1'b1;
					kind = KIND_STR;
					mode_n = (b == CH_BSLASH) ? MODE_STR_ESC : MODE_STR;
				end
				MODE_STR: begin
					tok_v = 1'b1;
					kind = KIND_STR;
					if (b == CH_DQUOTE) begin
						mode_n = MODE_IDLE;
					end else if (b == CH_BSLASH) begin
						mode_n = MODE_STR_ESC;
					end
				end
				MODE_TILDE: begin
					if (b == CH_AT) begin
						tok_v = 1'b1;
						kind = KIND_TILDE;
						mode_n = MODE_IDLE;
					end else begin
						do_idle = 1'b1;
					end
				end
				MODE_SYM: begin
					if (word) begin
						tok_v = 1'b1;
						kind = KIND_SYM;
					end else begin
						do_idle = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			if (do_idle) begin
				mode_n = MODE_IDLE;
				tok_v = 1'b1;
				start = 1'b1;
				if (word) begin
					kind = KIND_SYM;
					mode_n = MODE_SYM;
				end else begin
					unique case (b)
						CH_SPACE, CH_NL, CH_TAB, CH_COMMA: begin
							tok_v = 1'b0;
						end
						CH_SEMI: begin
							tok_v = 1'b0;
							mode_n = MODE_COMMENT;
						end
						CH_TILDE: begin
							kind = KIND_TILDE;
							mode_n = MODE_TILDE;
						end
						CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
							kind = KIND_OPEN;
							if (open_cnt_q == CNT_FULL) begin
								err = ERR_DEEP;
							end else begin
								push = 1'b1;
								cnt_n = open_cnt_q + CNT_ONE;
							end
						end
						CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
							kind = KIND_CLOSE;
							if (open_cnt_q == '0) begin
								err = ERR_ORPHAN;
							end else begin
								cnt_n = open_cnt_q - CNT_ONE;
							end
						end
						CH_SQUOTE, CH_BTICK, CH_CARET: begin
							kind = KIND_QUOTE;
						end
						CH_DQUOTE: begin
							kind = KIND_STR;
							mode_n = MODE_STR;
						end
						default: begin
							kind = KIND_OTHER;
						end
					endcase
				end
			end
		end

		end_v = stop0 || last;
		rd_cnt = stop0 ? open_cnt_q : cnt_n;
	end

	// Handshakes. The output stage doubles as the output register.
	assign busy = tok_v_s1 || end_v_s1;
	assign last_res = !(tok_v_s1 && end_v_s1);
	assign tokens.valid = busy;
	assign out_fire = tokens.valid && tokens.ready;
	assign source_text.ready = !busy || (tokens.ready && last_res);
	assign in_fire = source_text.valid && source_text.ready;

	// The top of stack after this byte is read every cycle; a push to that
	// same entry is caught by the forwarding register.
	assign mem_we = in_fire && push;
	assign mem_waddr = open_cnt_q[AW-1:0];
	assign mem_wdata = '{glyph: b, line: line_adv, col: col_adv};
	assign mem_raddr = AW'(rd_cnt - CNT_ONE);

	stl_ram #(
		.WIDTH($bits(stack_entry_t)),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign top_live = fwd_s1 ? fwd_data_s1 : mem_rdata;
	assign top = cap_q ? top_q : top_live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= 16'd1;
			col_q <= 16'd1;
			open_cnt_q <= '0;
			tok_v_s1 <= 1'b0;
			end_v_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			cap_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (end_v) begin
					mode_q <= MODE_IDLE;
					line_q <= 16'd1;
					col_q <= 16'd1;
					open_cnt_q <= '0;
				end else begin
					mode_q <= mode_n;
					line_q <= line_adv;
					col_q <= col_adv;
					open_cnt_q <= cnt_n;
				end
				tok_v_s1 <= tok_v;
				end_v_s1 <= end_v;
				fwd_s1 <= mem_we && (mem_waddr == mem_raddr);
				cap_q <= 1'b0;
			end else begin
				if (out_fire) begin
					if (!last_res) begin
						tok_v_s1 <= 1'b0;
					end else begin
						tok_v_s1 <= 1'b0;
						end_v_s1 <= 1'b0;
					end
				end
				// The RAM read data is only good until the read address moves on after
				// the load, so it is held here while the output stalls.
				if (busy && !cap_q) begin
					cap_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= b;
			kind_s1 <= kind;
			start_s1 <= start;
			err_s1 <= err;
			line_s1 <= line_adv;
			col_s1 <= col_adv;
			has_open_s1 <= (rd_cnt != '0);
			fwd_data_s1 <= mem_wdata;
		end else if (busy && !cap_q) begin
			top_q <= top_live;
		end
	end

	always_comb begin
		if (tok_v_s1) begin
			tokens.payload.out_byte = byte_s1;
			tokens.payload.token_kind = kind_s1;
			tokens.payload.token_start = start_s1;
			tokens.payload.stream_end = 1'b0;
			tokens.payload.error_code = err_s1;
			if (err_s1 != ERR_NONE) begin
				tokens.payload.error_glyph = byte_s1;
				tokens.payload.error_line = line_s1;
				tokens.payload.error_col = col_s1;
			end else begin
				tokens.payload.error_glyph = 8'd0;
				tokens.payload.error_line = 16'd0;
				tokens.payload.error_col = 16'd0;
			end
		end else begin
			tokens.payload.out_byte = 8'd0;
			tokens.payload.token_kind = KIND_NONE;
			tokens.payload.token_start = 1'b0;
			tokens.payload.stream_end = 1'b1;
			if (has_open_s1) begin
				tokens.payload.error_code = ERR_UNMATCHED;
				tokens.payload.error_glyph = top.glyph;
				tokens.payload.error_line = top.line;
				tokens.payload.error_col = top.col;
			end else begin
				tokens.payload.error_code = ERR_NONE;
				tokens.payload.error_glyph = 8'd0;
				tokens.payload.error_line = 16'd0;
				tokens.payload.error_col = 16'd0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_cnt_q <= CNT_FULL)
		else $error("bracket count beyond stack depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> open_cnt_q < CNT_FULL)
		else $error("push into a full stack");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && end_v) |=> (open_cnt_q == '0 && line_q == 16'd1 &&
		col_q == 16'd1 && mode_q == MODE_IDLE))
		else $error("state not cleared after end of stream");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && tokens.payload.error_code == ERR_DEEP) |->
		tokens.payload.token_kind == KIND_OPEN)
		else $error("nesting error on a byte that is not an opener");

	a_marker_after_token: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && tok_v_s1 && end_v_s1) |=> (tokens.valid &&
		tokens.payload.stream_end))
		else $error("end marker lost after its token");

endmodule
